[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, request and result types, codes and the sequencer states.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned NUM_REGIONS     = 4;
  localparam int unsigned REGION_BYTES    = 256;
  localparam int unsigned MIN_BLOCK_BYTES = 2;
  localparam int unsigned OWNER_W         = 8;
  localparam int unsigned SMALLEST_REQ    = 2;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_SIZE  = 2'd1;
  localparam logic [1:0] STAT_NO_SPACE  = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [8:0]         request_bytes;
    logic [OWNER_W-1:0] owner_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] block_start;
    logic [8:0] block_bytes;
  } rsp_t;

  typedef struct packed {
    logic               split;
    logic               taken;
    logic [OWNER_W-1:0] owner;
  } node_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ASCEND,
    ST_RETURN
  } state_e;

endpackage

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates power-of-two blocks from regions, each a binary tree of nodes in
// one RAM; a free releases an owner's blocks in the first region holding any.
//
//   Channel   Signals                    Handshake
//   request   start, busy, req_i         taken when start is high, busy low
//   result    done_o, rsp_o              one-cycle strobe, cannot be held off
//
// Each tree node visited is read from the RAM in the read state, then evaluated
// and written back in the evaluate state; the ascend or return state moves the
// walk on to its sibling or its parent. In the worst case an allocation or a
// free visits every node of each region it searches. The result appears in the
// cycle in which busy falls; an allocation with a bad size is answered in the
// next cycle and busy does not rise. After reset a clearing pass writes every
// RAM entry to zero (1020 entries at the defaults) with busy high.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned NumRegions    = NUM_REGIONS,
  parameter int unsigned RegionBytes   = REGION_BYTES,
  parameter int unsigned MinBlockBytes = MIN_BLOCK_BYTES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned Leaves = RegionBytes / MinBlockBytes;
  localparam int unsigned Levels = $clog2(Leaves) + 1;
  localparam int unsigned Nodes  = 2 * Leaves - 1;
  localparam int unsigned Total  = NumRegions * Nodes;
  localparam int unsigned AW     = $clog2(Total);
  localparam int unsigned NW     = Levels;
  localparam int unsigned LW     = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned OW     = $clog2(RegionBytes);
  localparam int unsigned BW     = OW + 1;
  localparam int unsigned RW     = (NumRegions > 1) ? $clog2(NumRegions) : 1;
  localparam int unsigned CW     = ((BW > 9) ? BW : 9) + 1;

  localparam logic [BW-1:0] RegionW = BW'(RegionBytes);
  localparam logic [BW-1:0] MinW    = BW'(MinBlockBytes);

  state_e state_q, state_d;

  logic              kind_q, kind_d;
  logic [OWNER_W-1:0] owner_q, owner_d;
  logic [BW-1:0]     want_q, want_d;
  logic [RW-1:0]     region_q, region_d;
  logic [AW-1:0]     base_q, base_d;
  logic [NW-1:0]     node_q, node_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [OW-1:0]     offs_q, offs_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              hit_q, hit_d;
  logic [OW-1:0]     hit_offs_q, hit_offs_d;
  logic [BW-1:0]     hit_bytes_q, hit_bytes_d;
  logic              ret_res_q, ret_res_d;
  logic              ret_clean_q, ret_clean_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;
  logic [Levels-1:0] any_q, any_d;
  logic [Levels-1:0] cl_q, cl_d;
  node_t             pw_q [Levels];
  node_t             pw_d [Levels];

  logic          we;
  logic [AW-1:0] waddr, raddr;
  node_t         wdata, rdata;

  logic [BW-1:0] cur_bytes;
  logic          leaf;
  logic [AW-1:0] node_addr, parent_addr;
  logic          last_region;
  logic [CW-1:0] req_ext;
  logic [BW-1:0] want_calc;
  logic          bad_size;
  logic [LW-1:0] plvl;
  logic          anyp, merge, newsplit;
  logic          accept;

  assign cur_bytes   = RegionW >> lvl_q;
  assign leaf        = (lvl_q == LW'(Levels - 1));
  assign node_addr   = base_q + AW'(node_q) - AW'(1);
  assign parent_addr = base_q + AW'(node_q >> 1) - AW'(1);
  assign last_region = (region_q == RW'(NumRegions - 1));
  assign plvl        = lvl_q - LW'(1);
  assign anyp        = any_q[plvl] | ret_res_q;
  assign merge       = anyp & cl_q[plvl] & ret_clean_q;
  assign newsplit    = merge ? 1'b0 : pw_q[plvl].split;
  assign accept      = start & ~busy;

  assign req_ext  = CW'(req_i.request_bytes);
  assign bad_size = (req_ext < CW'(SMALLEST_REQ)) || (req_ext > CW'(RegionBytes));

  always_comb begin
    want_calc = MinW;
    for (int i = 0; i < int'(OW); i++) begin
      if (CW'(BW'(1) << i) < req_ext && (BW'(1) << (i + 1)) > want_calc) begin
        want_calc = BW'(1) << (i + 1);
      end
    end
  end

  bba_ram #(
    .Width ($bits(node_t)),
    .Depth (Total)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(Total - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_ALLOC && bad_size) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (kind_q == KIND_ALLOC) begin
          if (rdata.taken || cur_bytes < want_q) begin
            state_d = ST_ASCEND;
          end else if (cur_bytes == want_q && !rdata.split) begin
            state_d = ST_IDLE;
          end else if (leaf) begin
            state_d = ST_ASCEND;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          if ((rdata.taken && rdata.owner == owner_q) || leaf) begin
            state_d = ST_RETURN;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_ASCEND: begin
        if (node_q == NW'(1)) begin
          state_d = last_region ? ST_IDLE : ST_READ;
        end else if (!node_q[0]) begin
          state_d = ST_READ;
        end
      end
      ST_RETURN: begin
        if (node_q == NW'(1)) begin
          state_d = (ret_res_q || last_region) ? ST_IDLE : ST_READ;
        end else if (!node_q[0]) begin
          state_d = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    owner_d     = owner_q;
    want_d      = want_q;
    region_d    = region_q;
    base_d      = base_q;
    node_d      = node_q;
    lvl_d       = lvl_q;
    offs_d      = offs_q;
    clr_d       = clr_q;
    hit_d       = hit_q;
    hit_offs_d  = hit_offs_q;
    hit_bytes_d = hit_bytes_q;
    ret_res_d   = ret_res_q;
    ret_clean_d = ret_clean_q;
    any_d       = any_q;
    cl_d        = cl_q;
    pw_d        = pw_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = node_addr;
    wdata       = rdata;
    raddr       = node_addr;

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d   = req_i.kind;
          owner_d  = req_i.owner_id;
          want_d   = want_calc;
          region_d = '0;
          base_d   = '0;
          node_d   = NW'(1);
          lvl_d    = '0;
          offs_d   = '0;
          hit_d    = 1'b0;
          if (req_i.kind == KIND_ALLOC && bad_size) begin
            done_d = 1'b1;
            rsp_d  = '{status: STAT_BAD_SIZE, block_start: '0, block_bytes: '0};
          end
        end
      end
      ST_EVAL: begin
        if (kind_q == KIND_ALLOC) begin
          if (rdata.taken || cur_bytes < want_q) begin
            // Climb in the ascend state.
          end else if (cur_bytes == want_q && !rdata.split) begin
            we     = 1'b1;
            wdata  = '{split: 1'b0, taken: 1'b1, owner: owner_q};
            done_d = 1'b1;
            rsp_d  = '{status: STAT_OK,
                       block_start: 10'({region_q, offs_q}),
                       block_bytes: 9'(cur_bytes)};
          end else if (!leaf) begin
            we     = 1'b1;
            wdata  = '{split: 1'b1, taken: 1'b0, owner: rdata.owner};
            node_d = node_q << 1;
            lvl_d  = lvl_q + LW'(1);
          end
        end else begin
          if (rdata.taken && rdata.owner == owner_q) begin
            we          = 1'b1;
            wdata       = '{split: rdata.split, taken: 1'b0, owner: rdata.owner};
            ret_res_d   = 1'b1;
            ret_clean_d = ~rdata.split;
            if (!hit_q) begin
              hit_d       = 1'b1;
              hit_offs_d  = offs_q;
              hit_bytes_d = cur_bytes;
            end
          end else if (leaf) begin
            ret_res_d   = 1'b0;
            ret_clean_d = ~rdata.taken & ~rdata.split;
          end else begin
            any_d[lvl_q] = 1'b0;
            pw_d[lvl_q]  = rdata;
            node_d       = node_q << 1;
            lvl_d        = lvl_q + LW'(1);
          end
        end
      end
      ST_ASCEND: begin
        if (node_q == NW'(1)) begin
          if (last_region) begin
            done_d = 1'b1;
            rsp_d  = '{status: STAT_NO_SPACE, block_start: '0, block_bytes: '0};
          end else begin
            region_d = region_q + RW'(1);
            base_d   = base_q + AW'(Nodes);
            offs_d   = '0;
          end
        end else if (!node_q[0]) begin
          node_d = node_q + NW'(1);
          offs_d = offs_q + OW'(cur_bytes);
        end else begin
          node_d = node_q >> 1;
          lvl_d  = plvl;
          offs_d = offs_q - OW'(cur_bytes);
        end
      end
      ST_RETURN: begin
        if (node_q == NW'(1)) begin
          if (ret_res_q) begin
            done_d = 1'b1;
            rsp_d  = '{status: STAT_OK,
                       block_start: 10'({region_q, hit_offs_q}),
                       block_bytes: 9'(hit_bytes_q)};
          end else if (last_region) begin
            done_d = 1'b1;
            rsp_d  = '{status: STAT_NOT_FOUND, block_start: '0, block_bytes: '0};
          end else begin
            region_d = region_q + RW'(1);
            base_d   = base_q + AW'(Nodes);
            offs_d   = '0;
          end
        end else if (!node_q[0]) begin
          any_d[plvl] = anyp;
          cl_d[plvl]  = ret_clean_q;
          node_d      = node_q + NW'(1);
          offs_d      = offs_q + OW'(cur_bytes);
        end else begin
          we          = anyp;
          waddr       = parent_addr;
          wdata       = '{split: newsplit, taken: pw_q[plvl].taken, owner: pw_q[plvl].owner};
          ret_res_d   = anyp;
          ret_clean_d = ~pw_q[plvl].taken & ~newsplit;
          node_d      = node_q >> 1;
          lvl_d       = plvl;
          offs_d      = offs_q - OW'(cur_bytes);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    owner_q     <= owner_d;
    want_q      <= want_d;
    region_q    <= region_d;
    base_q      <= base_d;
    node_q      <= node_d;
    lvl_q       <= lvl_d;
    offs_q      <= offs_d;
    hit_q       <= hit_d;
    hit_offs_q  <= hit_offs_d;
    hit_bytes_q <= hit_bytes_d;
    ret_res_q   <= ret_res_d;
    ret_clean_q <= ret_clean_d;
    any_q       <= any_d;
    cl_q        <= cl_d;
    pw_q        <= pw_d;
    rsp_q       <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[rtl/bba_checker.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator port checker
// Checks request and result timing and result consistency at the ports.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !(req_i.kind == KIND_ALLOC
      && (req_i.request_bytes < 9'd2 || req_i.request_bytes > 9'(REGION_BYTES))))
    |=> busy)
    else $error("A valid request did not make the block busy.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("A result was shown while the block was still busy.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STAT_OK) |-> (rsp_o.block_bytes == '0
      && rsp_o.block_start == '0))
    else $error("A failed request reported a block.");

  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == STAT_OK) |-> $onehot(rsp_o.block_bytes))
    else $error("A successful request reported a size that is not a power of two.");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free requests through the command port and checks every
// result against a behavioural tree model of the four regions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bba_pkg::*;

  localparam int NodesPerRegion = 255;
  localparam int WatchdogLimit  = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  req_t req_i = '0;
  rsp_t rsp_o;

  bit       tree_split [NUM_REGIONS][NodesPerRegion+1];
  bit       tree_taken [NUM_REGIONS][NodesPerRegion+1];
  bit [7:0] tree_owner [NUM_REGIONS][NodesPerRegion+1];
  int unsigned hit_start;
  int unsigned hit_bytes;
  bit          hit_valid;

  req_t pending_reqs[$];
  rsp_t awaited_rsps[$];
  int   send_idle_pct = 0;
  int   errors = 0;
  int   accepted = 0;
  int   n_ok = 0, n_bad = 0, n_full = 0, n_missing = 0, n_freed = 0;
  int   quiet_cycles = 0;
  bit   stim_done = 1'b0;

  buddy_block_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit take_node(int r, int n, int unsigned bytes, int unsigned base,
                                   int unsigned want, bit [7:0] owner);
    bit found;
    if (tree_taken[r][n] || bytes < want) return 1'b0;
    if (bytes == want && !tree_split[r][n]) begin
      tree_taken[r][n] = 1'b1;
      tree_owner[r][n] = owner;
      hit_start = base;
      hit_bytes = bytes;
      return 1'b1;
    end
    if (bytes < 2 * MIN_BLOCK_BYTES) return 1'b0;
    tree_split[r][n] = 1'b1;
    found = take_node(r, 2 * n, bytes / 2, base, want, owner);
    if (!found) found = take_node(r, 2 * n + 1, bytes / 2, base + bytes / 2, want, owner);
    return found;
  endfunction

  function automatic bit release_node(int r, int n, int unsigned bytes, int unsigned base,
                                      bit [7:0] owner);
    bit lf, rt;
    if (tree_taken[r][n] && tree_owner[r][n] == owner) begin
      tree_taken[r][n] = 1'b0;
      if (!hit_valid) begin
        hit_valid = 1'b1;
        hit_start = base;
        hit_bytes = bytes;
      end
      return 1'b1;
    end
    if (bytes < 2 * MIN_BLOCK_BYTES) return 1'b0;
    lf = release_node(r, 2 * n, bytes / 2, base, owner);
    rt = release_node(r, 2 * n + 1, bytes / 2, base + bytes / 2, owner);
    if ((lf || rt) && !tree_taken[r][2*n] && !tree_split[r][2*n]
        && !tree_taken[r][2*n+1] && !tree_split[r][2*n+1])
      tree_split[r][n] = 1'b0;
    return lf || rt;
  endfunction

  function automatic rsp_t predict_allocator(req_t rq);
    rsp_t rs;
    int unsigned want;
    bit found;
    found = 1'b0;
    rs = '0;
    hit_valid = 1'b0;
    if (rq.kind == KIND_ALLOC) begin
      if (rq.request_bytes < SMALLEST_REQ || rq.request_bytes > REGION_BYTES) begin
        rs.status = STAT_BAD_SIZE;
      end else begin
        want = MIN_BLOCK_BYTES;
        while (want < rq.request_bytes) want = want << 1;
        for (int r = 0; r < NUM_REGIONS && !found; r++) begin
          if (take_node(r, 1, REGION_BYTES, 0, want, rq.owner_id)) begin
            found = 1'b1;
            rs.block_start = 10'(r * REGION_BYTES + hit_start);
            rs.block_bytes = 9'(hit_bytes);
          end
        end
        rs.status = found ? STAT_OK : STAT_NO_SPACE;
      end
    end else begin
      for (int r = 0; r < NUM_REGIONS && !found; r++) begin
        if (release_node(r, 1, REGION_BYTES, 0, rq.owner_id)) begin
          found = 1'b1;
          rs.block_start = 10'(r * REGION_BYTES + hit_start);
          rs.block_bytes = 9'(hit_bytes);
        end
      end
      rs.status = found ? STAT_OK : STAT_NOT_FOUND;
    end
    return rs;
  endfunction

  function automatic req_t make_req(logic kind, int unsigned nbytes, int unsigned owner);
    req_t rq;
    rq.kind = kind;
    rq.request_bytes = nbytes[8:0];
    rq.owner_id = owner[7:0];
    return rq;
  endfunction

  // Driver: offers the oldest pending request at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_i <= pending_reqs[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      quiet_cycles <= 0;
      if (awaited_rsps.size() == 0) begin
        $error("result with no request outstanding: %p", rsp_o);
        errors++;
      end else begin
        exp_rsp = awaited_rsps.pop_front();
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.block_start !== exp_rsp.block_start) begin
          $error("block_start: expected %0d, got %0d", exp_rsp.block_start,
                 rsp_o.block_start);
          errors++;
        end
        if (rsp_o.block_bytes !== exp_rsp.block_bytes) begin
          $error("block_bytes: expected %0d, got %0d", exp_rsp.block_bytes,
                 rsp_o.block_bytes);
          errors++;
        end
        case (exp_rsp.status)
          STAT_OK:        if (exp_rsp.block_bytes != 0) n_ok++;
          STAT_BAD_SIZE:  n_bad++;
          STAT_NO_SPACE:  n_full++;
          default:        n_missing++;
        endcase
      end
    end else if (rst_ni && !(start && !busy)) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
    if (rst_ni && start && !busy) begin
      accepted++;
      awaited_rsps.push_back(predict_allocator(req_i));
      void'(pending_reqs.pop_front());
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[buddy_block_allocator] ERROR");
      $finish;
    end
  end

  task automatic queue_random_phase(int count);
    int unsigned sel;
    int unsigned sz;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        sz = ($urandom_range(3) == 0) ? $urandom_range(256, 2)
                                      : (1 << $urandom_range(6, 1)) - $urandom_range(1);
        if (sz < 2) sz = 2;
        pending_reqs.push_back(make_req(KIND_ALLOC, sz, $urandom_range(15)));
      end else if (sel < 85) begin
        pending_reqs.push_back(make_req(KIND_FREE, $urandom_range(511), $urandom_range(15)));
      end else if (sel < 95) begin
        sz = $urandom_range(1) ? $urandom_range(1) : $urandom_range(511, 257);
        pending_reqs.push_back(make_req(KIND_ALLOC, sz, $urandom_range(255)));
      end else begin
        pending_reqs.push_back(make_req(KIND_FREE, $urandom_range(511), $urandom_range(255)));
      end
    end
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || awaited_rsps.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int idle_phase[4] = '{0, 82, 0, 18};
    for (int r = 0; r < NUM_REGIONS; r++) begin
      for (int n = 0; n <= NodesPerRegion; n++) begin
        tree_split[r][n] = 1'b0;
        tree_taken[r][n] = 1'b0;
        tree_owner[r][n] = '0;
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: size extremes, whole regions, exhaustion and owner misses.
    pending_reqs.push_back(make_req(KIND_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 1, 0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 257, 0));
    pending_reqs.push_back(make_req(KIND_ALLOC, 511, 255));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 7));
    pending_reqs.push_back(make_req(KIND_ALLOC, 2, 1));
    pending_reqs.push_back(make_req(KIND_ALLOC, 3, 2));
    pending_reqs.push_back(make_req(KIND_ALLOC, 256, 255));
    pending_reqs.push_back(make_req(KIND_ALLOC, 256, 3));
    pending_reqs.push_back(make_req(KIND_ALLOC, 256, 4));
    pending_reqs.push_back(make_req(KIND_ALLOC, 129, 5));
    pending_reqs.push_back(make_req(KIND_ALLOC, 256, 6));
    pending_reqs.push_back(make_req(KIND_ALLOC, 2, 1));
    pending_reqs.push_back(make_req(KIND_FREE, 511, 1));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 255));
    pending_reqs.push_back(make_req(KIND_ALLOC, 256, 0));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 2));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 1));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 3));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 4));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 5));
    pending_reqs.push_back(make_req(KIND_FREE, 0, 0));
    drain();

    foreach (idle_phase[p]) begin
      send_idle_pct = idle_phase[p];
      queue_random_phase(450);
      drain();
    end
    stim_done = 1'b1;
    repeat (50) @(posedge clk_i);

    $display("Checked %0d requests: %0d blocks granted or released, %0d bad sizes,",
             accepted, n_ok, n_bad);
    $display("%0d allocations without space and %0d frees of unknown owners.",
             n_full, n_missing);
    if (errors == 0 && awaited_rsps.size() == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
